// ===== hw/rtl/fthn_pkg.sv =====
// Shared types and codes for the forwarding table next-hop core.
// No dependencies; every other file of the block refers to it by scoped names.
package fthn_pkg;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_FLUSH  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_INVALID  = 2'd3;

    localparam logic [15:0] STAMP_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] dst_addr;
        logic [7:0]  qos_id;
        logic        port_present;
        logic [15:0] port_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        port_valid;
        logic [15:0] port_out;
        logic        last;
        logic        table_empty;
    } t_res;

    typedef enum logic [2:0] {
        K_ADD,
        K_REMOVE,
        K_LOOKUP,
        K_FLUSH,
        K_INVALID
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] dest;
        logic [7:0]  qos;
        logic        has_port;
        logic [15:0] port;
    } t_cmd;

    typedef struct packed {
        logic [31:0] dest;
        logic [7:0]  qos;
    } t_key;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_PSCAN,
        S_PSCAN_END,
        S_PDECIDE,
        S_SH_RD,
        S_SH_WR,
        S_REM_FIN,
        S_CMP_RDI,
        S_CMP_LDI,
        S_CMP_SCAN,
        S_CMP_END,
        S_CMP_WR,
        S_INSERT,
        S_EM_RD,
        S_EM_WR,
        S_RESP
    } t_state;

endpackage

// ===== hw/rtl/fthn_front.sv =====
// Front end: accepts request words, classifies them and queues them two deep.
// Depends on fthn_pkg.
module fthn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fthn_pkg::t_req i_in,
    output logic          o_cmd_valid,
    output fthn_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    fthn_pkg::t_cmd r_q [2];
    logic [1:0]     r_cnt;
    logic           r_rd;
    logic           r_wr;
    fthn_pkg::t_cmd n_cmd;
    logic           push;
    logic           pop;

    always_comb begin
        n_cmd.dest     = i_in.dst_addr;
        n_cmd.qos      = i_in.qos_id;
        n_cmd.has_port = i_in.port_present;
        n_cmd.port     = i_in.port_id;
        if (i_in.req_type == fthn_pkg::REQ_FLUSH) begin
            n_cmd.kind = fthn_pkg::K_FLUSH;
        end else if (i_in.dst_addr == 32'd0) begin
            n_cmd.kind = fthn_pkg::K_INVALID;
        end else if (i_in.req_type == fthn_pkg::REQ_ADD) begin
            n_cmd.kind = fthn_pkg::K_ADD;
        end else if (i_in.req_type == fthn_pkg::REQ_REMOVE) begin
            n_cmd.kind = fthn_pkg::K_REMOVE;
        end else begin
            n_cmd.kind = fthn_pkg::K_LOOKUP;
        end
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wr] <= n_cmd;
                r_wr      <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/fthn_back.sv =====
// Back end: table memories and the sequencer that scans, updates and emits.
// Depends on fthn_pkg.
module fthn_back #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_PORTS   = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  fthn_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_res_valid,
    output fthn_pkg::t_res o_res,
    input  logic           i_res_ready
);

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int CW = $clog2(MAX_PORTS + 1);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int PD = MAX_ENTRIES * MAX_PORTS;
    localparam int AW = (PD > 1) ? $clog2(PD) : 1;
    localparam int SD = 2 << EW;
    localparam logic [EW-1:0] LAST_E = EW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] FULL_P = CW'(MAX_PORTS);

    fthn_pkg::t_key ent_mem [MAX_ENTRIES];
    logic [15:0]    st_mem  [SD];
    logic [15:0]    pt_mem  [PD];

    fthn_pkg::t_state r_state, n_state;
    fthn_pkg::t_cmd   r_cmd;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [CW-1:0]  r_pcnt [MAX_ENTRIES];
    logic [CW-1:0]  r_bcnt;
    logic [15:0]    r_counter;
    logic [NW-1:0]  r_nvalid;
    logic           r_bank;
    logic [1:0]     r_status;

    logic [EW-1:0]  r_idx, r_cmp_idx, r_best, r_free, r_ci, r_j, r_ccmp_j;
    logic           r_cmp_vld, r_found, r_free_found;
    logic [15:0]    r_bstamp, r_si, r_rank;
    logic           r_ccmp_vld;
    logic [PW-1:0]  r_k, r_pcmp_k, r_pos;
    logic           r_pcmp_vld, r_pfound, r_dec;

    fthn_pkg::t_key r_erd;
    logic [15:0]    r_srd, r_prd;

    logic           em_we, sm_we, pm_we;
    logic [EW:0]    sm_waddr, sm_raddr;
    logic [15:0]    sm_wdata, pm_wdata;
    logic [AW-1:0]  pm_waddr, pm_raddr;
    logic [CW-1:0]  cnt, new_cnt;
    logic           match;

    function automatic logic [AW-1:0] pa(input logic [EW-1:0] e, input logic [CW-1:0] k);
        pa = AW'(e) * AW'(MAX_PORTS) + AW'(k);
    endfunction

    assign cnt     = r_bcnt;
    assign new_cnt = cnt - {{(CW-1){1'b0}}, r_dec};
    assign match   = r_valid[r_cmp_idx] && (r_erd.dest == r_cmd.dest)
                     && ((r_erd.qos == 8'd0) || (r_erd.qos == r_cmd.qos))
                     && (!r_found || (r_srd > r_bstamp));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fthn_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == fthn_pkg::K_FLUSH || i_cmd.kind == fthn_pkg::K_INVALID) begin
                        n_state = fthn_pkg::S_RESP;
                    end else begin
                        n_state = fthn_pkg::S_SCAN;
                    end
                end
            end
            fthn_pkg::S_SCAN: begin
                if (r_idx == LAST_E) begin
                    n_state = fthn_pkg::S_SCAN_END;
                end
            end
            fthn_pkg::S_SCAN_END: n_state = fthn_pkg::S_DECIDE;
            fthn_pkg::S_DECIDE: begin
                priority case (r_cmd.kind)
                    fthn_pkg::K_ADD: begin
                        if (r_found) begin
                            if (!r_cmd.has_port) begin
                                n_state = fthn_pkg::S_RESP;
                            end else if (cnt == '0) begin
                                n_state = fthn_pkg::S_PDECIDE;
                            end else begin
                                n_state = fthn_pkg::S_PSCAN;
                            end
                        end else if (!r_free_found) begin
                            n_state = fthn_pkg::S_RESP;
                        end else if (r_counter == fthn_pkg::STAMP_MAX) begin
                            n_state = fthn_pkg::S_CMP_RDI;
                        end else begin
                            n_state = fthn_pkg::S_INSERT;
                        end
                    end
                    fthn_pkg::K_REMOVE: begin
                        if (!r_found) begin
                            n_state = fthn_pkg::S_RESP;
                        end else if (r_cmd.has_port && cnt != '0) begin
                            n_state = fthn_pkg::S_PSCAN;
                        end else begin
                            n_state = fthn_pkg::S_REM_FIN;
                        end
                    end
                    default: begin
                        if (!r_found || cnt == '0) begin
                            n_state = fthn_pkg::S_RESP;
                        end else begin
                            n_state = fthn_pkg::S_EM_RD;
                        end
                    end
                endcase
            end
            fthn_pkg::S_PSCAN: begin
                if (CW'(r_k) == cnt - CW'(1)) begin
                    n_state = fthn_pkg::S_PSCAN_END;
                end
            end
            fthn_pkg::S_PSCAN_END: n_state = fthn_pkg::S_PDECIDE;
            fthn_pkg::S_PDECIDE: begin
                if (r_cmd.kind == fthn_pkg::K_ADD) begin
                    n_state = fthn_pkg::S_RESP;
                end else if (r_pfound && (CW'(r_pos) + CW'(1) < cnt)) begin
                    n_state = fthn_pkg::S_SH_RD;
                end else begin
                    n_state = fthn_pkg::S_REM_FIN;
                end
            end
            fthn_pkg::S_SH_RD: n_state = fthn_pkg::S_SH_WR;
            fthn_pkg::S_SH_WR: begin
                if (CW'(r_k) + CW'(2) < cnt) begin
                    n_state = fthn_pkg::S_SH_RD;
                end else begin
                    n_state = fthn_pkg::S_REM_FIN;
                end
            end
            fthn_pkg::S_REM_FIN: n_state = fthn_pkg::S_RESP;
            fthn_pkg::S_CMP_RDI: n_state = fthn_pkg::S_CMP_LDI;
            fthn_pkg::S_CMP_LDI: begin
                n_state = r_valid[r_ci] ? fthn_pkg::S_CMP_SCAN : fthn_pkg::S_CMP_WR;
            end
            fthn_pkg::S_CMP_SCAN: begin
                if (r_j == LAST_E) begin
                    n_state = fthn_pkg::S_CMP_END;
                end
            end
            fthn_pkg::S_CMP_END: n_state = fthn_pkg::S_CMP_WR;
            fthn_pkg::S_CMP_WR: begin
                n_state = (r_ci == LAST_E) ? fthn_pkg::S_INSERT : fthn_pkg::S_CMP_RDI;
            end
            fthn_pkg::S_INSERT: n_state = fthn_pkg::S_RESP;
            fthn_pkg::S_EM_RD: n_state = fthn_pkg::S_EM_WR;
            fthn_pkg::S_EM_WR: begin
                if (i_res_ready) begin
                    n_state = (r_k == '0) ? fthn_pkg::S_IDLE : fthn_pkg::S_EM_RD;
                end
            end
            fthn_pkg::S_RESP: begin
                if (i_res_ready) begin
                    n_state = fthn_pkg::S_IDLE;
                end
            end
            default: n_state = fthn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        em_we       = 1'b0;
        sm_we       = 1'b0;
        sm_waddr    = {r_bank, r_free};
        sm_wdata    = r_counter;
        sm_raddr    = {r_bank, r_idx};
        pm_we       = 1'b0;
        pm_waddr    = pa(r_best, CW'(r_k));
        pm_wdata    = r_cmd.port;
        pm_raddr    = pa(r_best, CW'(r_k));
        unique case (r_state)
            fthn_pkg::S_IDLE: o_cmd_pop = i_cmd_valid;
            fthn_pkg::S_PDECIDE: begin
                if (r_cmd.kind == fthn_pkg::K_ADD && !r_pfound && cnt != FULL_P) begin
                    pm_we    = 1'b1;
                    pm_waddr = pa(r_best, cnt);
                end
            end
            fthn_pkg::S_SH_RD: pm_raddr = pa(r_best, CW'(r_k) + CW'(1));
            fthn_pkg::S_SH_WR: begin
                pm_we    = 1'b1;
                pm_wdata = r_prd;
            end
            fthn_pkg::S_CMP_RDI: sm_raddr = {r_bank, r_ci};
            fthn_pkg::S_CMP_SCAN: sm_raddr = {r_bank, r_j};
            fthn_pkg::S_CMP_WR: begin
                sm_we    = r_valid[r_ci];
                sm_waddr = {~r_bank, r_ci};
                sm_wdata = r_rank;
            end
            fthn_pkg::S_INSERT: begin
                em_we    = 1'b1;
                sm_we    = 1'b1;
                pm_we    = r_cmd.has_port;
                pm_waddr = pa(r_free, '0);
            end
            fthn_pkg::S_EM_WR: begin
                o_res_valid      = 1'b1;
                o_res.status     = fthn_pkg::STAT_OK;
                o_res.port_valid = 1'b1;
                o_res.port_out   = r_prd;
                o_res.last       = (r_k == '0);
            end
            fthn_pkg::S_RESP: begin
                o_res_valid       = 1'b1;
                o_res.status      = r_status;
                o_res.last        = 1'b1;
                o_res.table_empty = (r_nvalid == '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (em_we) begin
            ent_mem[r_free] <= '{dest: r_cmd.dest, qos: r_cmd.qos};
        end
        r_erd <= ent_mem[r_idx];
        if (sm_we) begin
            st_mem[sm_waddr] <= sm_wdata;
        end
        r_srd <= st_mem[sm_raddr];
        if (pm_we) begin
            pt_mem[pm_waddr] <= pm_wdata;
        end
        r_prd <= pt_mem[pm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fthn_pkg::S_IDLE;
            r_valid    <= '0;
            r_counter  <= '0;
            r_nvalid   <= '0;
            r_bank     <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_pcmp_vld <= 1'b0;
            r_ccmp_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_vld  <= (r_state == fthn_pkg::S_SCAN);
            r_cmp_idx  <= r_idx;
            r_pcmp_vld <= (r_state == fthn_pkg::S_PSCAN);
            r_pcmp_k   <= r_k;
            r_ccmp_vld <= (r_state == fthn_pkg::S_CMP_SCAN);
            r_ccmp_j   <= r_j;
            if (r_cmp_vld && match) begin
                r_found  <= 1'b1;
                r_best   <= r_cmp_idx;
                r_bstamp <= r_srd;
                r_bcnt   <= r_pcnt[r_cmp_idx];
            end
            if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free       <= r_cmp_idx;
            end
            if (r_pcmp_vld && !r_pfound && r_prd == r_cmd.port) begin
                r_pfound <= 1'b1;
                r_pos    <= r_pcmp_k;
            end
            if (r_ccmp_vld && r_valid[r_ccmp_j] && r_srd < r_si) begin
                r_rank <= r_rank + 16'd1;
            end
            unique case (r_state)
                fthn_pkg::S_IDLE: begin
                    r_idx        <= '0;
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.kind == fthn_pkg::K_FLUSH) begin
                            r_valid   <= '0;
                            r_counter <= '0;
                            r_nvalid  <= '0;
                            r_status  <= fthn_pkg::STAT_OK;
                        end else begin
                            r_status <= fthn_pkg::STAT_INVALID;
                        end
                    end
                end
                fthn_pkg::S_SCAN: r_idx <= r_idx + EW'(1);
                fthn_pkg::S_DECIDE: begin
                    r_k      <= '0;
                    r_pfound <= 1'b0;
                    r_dec    <= 1'b0;
                    r_ci     <= '0;
                    r_status <= fthn_pkg::STAT_OK;
                    if (r_cmd.kind == fthn_pkg::K_ADD) begin
                        if (!r_found && !r_free_found) begin
                            r_status <= fthn_pkg::STAT_FULL;
                        end
                    end else if (!r_found) begin
                        r_status <= fthn_pkg::STAT_NOTFOUND;
                    end else if (r_cmd.kind == fthn_pkg::K_LOOKUP) begin
                        r_k <= PW'(cnt - CW'(1));
                    end
                end
                fthn_pkg::S_PSCAN: r_k <= r_k + PW'(1);
                fthn_pkg::S_PDECIDE: begin
                    r_status <= fthn_pkg::STAT_OK;
                    if (r_cmd.kind == fthn_pkg::K_ADD) begin
                        if (!r_pfound) begin
                            if (cnt == FULL_P) begin
                                r_status <= fthn_pkg::STAT_FULL;
                            end else begin
                                r_pcnt[r_best] <= cnt + CW'(1);
                            end
                        end
                    end else begin
                        r_k   <= r_pos;
                        r_dec <= r_pfound;
                    end
                end
                fthn_pkg::S_SH_WR: r_k <= r_k + PW'(1);
                fthn_pkg::S_REM_FIN: begin
                    r_status       <= fthn_pkg::STAT_OK;
                    r_pcnt[r_best] <= new_cnt;
                    if (new_cnt == '0) begin
                        r_valid[r_best] <= 1'b0;
                        r_nvalid        <= r_nvalid - NW'(1);
                    end
                end
                fthn_pkg::S_CMP_LDI: begin
                    r_si   <= r_srd;
                    r_j    <= '0;
                    r_rank <= '0;
                end
                fthn_pkg::S_CMP_SCAN: r_j <= r_j + EW'(1);
                fthn_pkg::S_CMP_WR: begin
                    if (r_ci == LAST_E) begin
                        r_bank    <= ~r_bank;
                        r_counter <= 16'(r_nvalid);
                    end else begin
                        r_ci <= r_ci + EW'(1);
                    end
                end
                fthn_pkg::S_INSERT: begin
                    r_valid[r_free] <= 1'b1;
                    r_pcnt[r_free]  <= r_cmd.has_port ? CW'(1) : '0;
                    r_counter       <= r_counter + 16'd1;
                    r_nvalid        <= r_nvalid + NW'(1);
                    r_status        <= fthn_pkg::STAT_OK;
                end
                fthn_pkg::S_EM_WR: begin
                    if (i_res_ready && r_k != '0) begin
                        r_k <= r_k - PW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/fthn_out.sv =====
// Output register: holds one result word while the receiver stalls.
// Depends on fthn_pkg.
module fthn_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_res_valid,
    input  fthn_pkg::t_res i_res,
    output logic           o_res_ready,
    output logic           o_out_valid,
    output fthn_pkg::t_res o_out,
    input  logic           i_out_stall
);

    logic           r_valid;
    fthn_pkg::t_res r_data;

    assign o_res_ready = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out       = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
            if (i_res_valid) begin
                r_data <= i_res;
            end
        end
    end

endmodule

// ===== hw/rtl/forwarding_table_next_hop_core.sv =====
// Forwarding table next-hop core: add, remove, lookup and flush of entries keyed by
// destination and QoS, each with an ordered port set. Every add, remove and lookup first
// scans all MAX_ENTRIES entries through the key memory, one entry a cycle; then an add
// or remove that names a port scans the entry's ports, and a remove shifts the later
// ports down, a read and a write for each; a lookup emits its ports one at a time,
// holding while the output stalls. When the 16-bit insertion stamp runs out, the next
// insertion first renumbers all stamps. Requests queue two deep in front.
module forwarding_table_next_hop_core #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_PORTS   = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fthn_pkg::t_req i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fthn_pkg::t_res o_out
);

    logic           cmd_valid, cmd_pop, res_valid, res_ready;
    fthn_pkg::t_cmd cmd;
    fthn_pkg::t_res res;

    fthn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    fthn_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_PORTS   (MAX_PORTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    fthn_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule
